// ===== hdl/rgb_to_cry_palette_match_assert.svh =====
// ---------------------------------------------------------------------------
// rgb_to_cry_palette_match_assert.svh
// Assertion macros used by the checker file of the CRY converter.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_CRY_PALETTE_MATCH_ASSERT_SVH
`define RGB_TO_CRY_PALETTE_MATCH_ASSERT_SVH

// Same-cycle implication.
`define RCPM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rcpm assertion failed");

// Next-cycle implication.
`define RCPM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rcpm assertion failed");

`endif

// ===== hdl/rcpm_pkg.sv =====
// ---------------------------------------------------------------------------
// rcpm_pkg
// Types, codes and helpers of the RGB to CRY palette matcher.
// ---------------------------------------------------------------------------
package rcpm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_CONVERT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_SRCH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  localparam int unsigned EPOCH_W  = 4;
  localparam int unsigned CACHE_AW = 16;

  typedef logic [EPOCH_W-1:0] epoch_t;
  typedef logic [9:0]         dist_t;

  typedef struct packed {
    epoch_t     epoch;
    logic [7:0] index;
  } cache_entry_t;

  localparam logic [7:0] BLACK_CHROMA = 8'd135;
  // Larger than any L1 distance (max 765), so entry 1 always qualifies.
  localparam dist_t      FAR_DIST     = 10'h3ff;
  localparam epoch_t     EPOCH_FIRST  = epoch_t'(1);
  localparam epoch_t     EPOCH_LAST   = '1;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hdl/rcpm_div.sv =====
// ---------------------------------------------------------------------------
// rcpm_div
// Radix-2 restoring divider for c*255/y with c <= y, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rcpm_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] num_i,
  input  logic [7:0] den_i,
  output logic       done_o,
  output logic [7:0] quot_o
);

  logic [15:0] dvd;
  logic [8:0]  trial;
  logic        ge;
  logic [7:0]  rem_next;
  logic [7:0]  rem_q, low_q, quot_q, den_q;
  logic [2:0]  cnt_q;
  logic        busy_q, done_q;

  // c*255 < 256*y, so the upper byte is already below y and the quotient fits 8 bits
  assign dvd      = {num_i, 8'h00} - {8'h00, num_i};
  assign trial    = {rem_q, low_q[7]};
  assign ge       = trial >= {1'b0, den_q};
  assign rem_next = ge ? 8'(trial - {1'b0, den_q}) : trial[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dvd[15:8];
      low_q  <= dvd[7:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_next;
      low_q  <= {low_q[6:0], 1'b0};
      quot_q <= {quot_q[6:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/rcpm_search.sv =====
// ---------------------------------------------------------------------------
// rcpm_search
// Palette memory and nearest-entry scan (L1 distance, ties to later entry).
// ---------------------------------------------------------------------------
module rcpm_search #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  rcpm_pkg::color_t   wr_data_i,
  input  logic               start_i,
  input  rcpm_pkg::color_t   color_i,
  output logic               done_o,
  output logic [7:0]         index_o
);

  import rcpm_pkg::*;

  localparam logic [IDX_W-1:0] K_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] K_LAST  = IDX_W'(PALETTE_ENTRIES - 1);

  color_t           pal_mem [PALETTE_ENTRIES];
  color_t           rd_q;
  logic [IDX_W-1:0] k_q, rk_q, best_idx_q;
  logic             issue_q, rv_q, rlast_q, done_q;
  dist_t            best_q;
  dist_t            cand_dist;

  assign cand_dist = {2'b00, abs_diff(color_i.r, rd_q.r)}
                   + {2'b00, abs_diff(color_i.g, rd_q.g)}
                   + {2'b00, abs_diff(color_i.b, rd_q.b)};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pal_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q    <= pal_mem[k_q];
    rk_q    <= k_q;
    rlast_q <= (k_q == K_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
      k_q     <= K_FIRST;
    end else begin
      rv_q   <= issue_q;
      done_q <= rv_q && rlast_q;
      if (start_i) begin
        issue_q <= 1'b1;
        k_q     <= K_FIRST;
      end else if (issue_q) begin
        if (k_q == K_LAST) begin
          issue_q <= 1'b0;
        end else begin
          k_q <= k_q + K_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_q     <= FAR_DIST;
      best_idx_q <= K_FIRST;
    end else if (rv_q && (cand_dist <= best_q)) begin
      best_q     <= cand_dist;
      best_idx_q <= rk_q;
    end
  end

  assign done_o  = done_q;
  assign index_o = 8'(best_idx_q);

endmodule

// ===== hdl/rgb_to_cry_palette_match.sv =====
// ---------------------------------------------------------------------------
// rgb_to_cry_palette_match
// Converts RGB pixels to CRY (chroma palette index and luminance).
// ---------------------------------------------------------------------------
// One item at a time. Loads and clears are taken in the idle state. A black
// pixel goes straight to output; any other pixel passes through the three
// parallel 8-step dividers that scale the color by 255/Y and the registered
// cache read. A cache miss adds the palette scan, one palette read per cycle.
// The color cache uses an epoch tag; after reset, and on every 15th clear, a
// sweep writes all 65536 cache entries, one per cycle, while no transfer is
// accepted.
module rgb_to_cry_palette_match #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // chroma_index[7:0], luminance[15:8]
);

  import rcpm_pkg::*;

  localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  state_e              state_q, state_d;
  logic [CACHE_AW-1:0] sweep_q, sweep_d;
  epoch_t              epoch_q, epoch_d;
  logic [7:0]          y_q, y_d, chroma_q, chroma_d;
  logic                m_valid_q, m_valid_d;
  logic [15:0]         m_data_q, m_data_d;

  logic                accept;
  cmd_e                cmd;
  logic [7:0]          in_idx;
  color_t              in_color;
  logic [7:0]          y_in;

  logic                div_start, div_done;
  logic [2:0]          lane_done;
  color_t              scaled;

  logic                pal_we;
  logic                srch_start, srch_done;
  logic [7:0]          srch_idx;

  cache_entry_t        cache_mem [2**CACHE_AW];
  cache_entry_t        cache_rd_q, cache_wdata;
  logic                cache_we;
  logic [CACHE_AW-1:0] cache_waddr, cache_key;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd        = cmd_e'(s_axis_tuser_i);
  assign in_idx     = s_axis_tdata_i[7:0];
  assign in_color.r = s_axis_tdata_i[15:8];
  assign in_color.g = s_axis_tdata_i[23:16];
  assign in_color.b = s_axis_tdata_i[31:24];

  always_comb begin
    y_in = in_color.r;
    if (in_color.g > y_in) y_in = in_color.g;
    if (in_color.b > y_in) y_in = in_color.b;
  end

  rcpm_div u_div_r (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(in_color.r), .den_i(y_in),
    .done_o(lane_done[0]), .quot_o(scaled.r)
  );
  rcpm_div u_div_g (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(in_color.g), .den_i(y_in),
    .done_o(lane_done[1]), .quot_o(scaled.g)
  );
  rcpm_div u_div_b (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(in_color.b), .den_i(y_in),
    .done_o(lane_done[2]), .quot_o(scaled.b)
  );
  assign div_done = &lane_done;

  rcpm_search #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_search (
    .clk_i,
    .rst_ni,
    .wr_en_i   (pal_we),
    .wr_addr_i (in_idx[IDX_W-1:0]),
    .wr_data_i (in_color),
    .start_i   (srch_start),
    .color_i   (scaled),
    .done_o    (srch_done),
    .index_o   (srch_idx)
  );

  // 5:6:5 key of the scaled color
  assign cache_key = {scaled.r[7:3], scaled.g[7:2], scaled.b[7:3]};

  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    cache_rd_q <= cache_mem[cache_key];
  end

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    epoch_d     = epoch_q;
    y_d         = y_q;
    chroma_d    = chroma_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    div_start   = 1'b0;
    srch_start  = 1'b0;
    pal_we      = 1'b0;
    cache_we    = 1'b0;
    cache_waddr = cache_key;
    cache_wdata = '{epoch: epoch_q, index: srch_idx};
    case (state_q)
      ST_SWEEP: begin
        cache_we    = 1'b1;
        cache_waddr = sweep_q;
        cache_wdata = '0;
        sweep_d     = sweep_q + 1'b1;
        if (&sweep_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_LOAD: begin
              pal_we = {1'b0, in_idx} < 9'(PALETTE_ENTRIES);
            end
            CMD_CLEAR: begin
              if (epoch_q == EPOCH_LAST) begin
                epoch_d = EPOCH_FIRST;
                state_d = ST_SWEEP;
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
            end
            CMD_CONVERT: begin
              y_d = y_in;
              if (y_in == 8'd0) begin
                chroma_d = BLACK_CHROMA;
                state_d  = ST_OUT;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cache_rd_q.epoch == epoch_q) begin
          chroma_d = cache_rd_q.index;
          state_d  = ST_OUT;
        end else begin
          srch_start = 1'b1;
          state_d    = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (srch_done) begin
          chroma_d = srch_idx;
          cache_we = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {y_q, chroma_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      sweep_q   <= '0;
      epoch_q   <= EPOCH_FIRST;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      epoch_q   <= epoch_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    chroma_q <= chroma_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hdl/rcpm_checker.sv =====
// ---------------------------------------------------------------------------
// rcpm_checker
// Port-level checks of the RGB to CRY palette matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "rgb_to_cry_palette_match_assert.svh"

module rcpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_i,
  input logic [31:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_i
);

  import rcpm_pkg::*;

  logic in_xfer;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_i;

  `RCPM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i))
  `RCPM_ASSERT_NXT(a_convert_busy, clk_i, rst_ni, in_xfer && (s_axis_tuser_i == CMD_CONVERT), !s_axis_tready_i)
  `RCPM_ASSERT_NXT(a_load_ready, clk_i, rst_ni, in_xfer && (s_axis_tuser_i == CMD_LOAD), s_axis_tready_i)
  `RCPM_ASSERT_IMP(a_chroma_nonzero, clk_i, rst_ni, m_axis_tvalid_i, m_axis_tdata_i[7:0] != 8'd0)

endmodule

bind rgb_to_cry_palette_match rcpm_checker u_rcpm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
